// ----- src/uart_telemetry_command_handler_top_assert.svh -----
// ----------------------------------------------------------------------------
// Assertion macros for the serial telemetry and command handler
// Concurrent checks on clk with the asynchronous reset masked; empty bodies
// when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef UART_TELEMETRY_COMMAND_HANDLER_TOP_ASSERT_SVH
`define UART_TELEMETRY_COMMAND_HANDLER_TOP_ASSERT_SVH

`ifndef SYNTHESIS

// Same-cycle implication.
`define UTCH_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define UTCH_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`else

`define UTCH_ASSERT_IMP(lbl, ante, cons, msg)
`define UTCH_ASSERT_NXT(lbl, ante, cons, msg)

`endif

`endif

// ----- src/utch_pkg.sv -----
// ----------------------------------------------------------------------------
// utch_pkg
// Types and constants shared by the serial telemetry and command handler.
// ----------------------------------------------------------------------------
`default_nettype none

package utch_pkg;

    // Reply geometry: every reply is a fixed burst of bytes.
    localparam int REPLY_BYTES = 8;
    localparam int BYTE_IDX_W  = $clog2(REPLY_BYTES);
    localparam logic [BYTE_IDX_W-1:0] LAST_BYTE = BYTE_IDX_W'(REPLY_BYTES - 1);

    // Operation codes of an input item.
    localparam logic OP_RX_BYTE  = 1'b0;
    localparam logic OP_TX_EMPTY = 1'b1;

    // Characters of the protocol.
    localparam logic [7:0] CH_TELEMETRY = 8'h41; // 'A'
    localparam logic [7:0] CH_VERSION   = 8'h43; // 'C'
    localparam logic [7:0] CH_BUCK      = 8'h4B; // 'K'
    localparam logic [7:0] CH_BOOST     = 8'h54; // 'T'
    localparam logic [7:0] CH_VER_TAG   = 8'h76; // 'v'
    localparam logic [7:0] CH_ZERO      = 8'h30; // '0'
    localparam logic [7:0] CH_LOW_A     = 8'h61; // 'a'
    localparam logic [7:0] CH_LOW_C     = 8'h63; // 'c'
    localparam logic [7:0] CH_LOW_K     = 8'h6B; // 'k'

    // Configuration register indexes.
    localparam int CFG_IDX_W = 3;
    localparam logic [CFG_IDX_W-1:0] REG_ENABLE      = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_VERSION_0   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_VERSION_1   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_VERSION_2   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_VERSION_CHK = 3'd4;
    localparam int CFG_DATA_W = 16;

    // Input item.
    typedef struct packed {
        logic        op;
        logic [7:0]  rx_byte;
        logic        framing_error;
        logic        overrun;
        logic [15:0] output_voltage;
        logic [15:0] input_voltage;
        logic [15:0] phase_current_a;
        logic [15:0] phase_current_b;
    } cmd_item_t;

    // Result item.
    typedef struct packed {
        logic [7:0]  tx_byte;
        logic        last;
        logic        vref_write;
        logic [15:0] vref_value;
    } rsp_item_t;

    // Configuration register file contents.
    typedef struct packed {
        logic             enable;
        logic [2:0][15:0] version_word;
        logic [7:0]       version_check_byte;
    } cfg_t;

    // One complete reply, byte 0 sent first.
    typedef struct packed {
        logic [REPLY_BYTES-1:0][7:0] bytes;
        logic                        vref_write;
        logic [15:0]                 vref_value;
    } reply_t;

    // Push request from the front end into the reply queue.
    typedef struct packed {
        logic   valid;
        reply_t reply;
    } reply_push_t;

endpackage

`default_nettype wire

// ----- src/utch_front.sv -----
// ----------------------------------------------------------------------------
// utch_front
// Accepts input items, tracks the command and frame state, and builds the
// complete reply for each item that calls for one.
// ----------------------------------------------------------------------------
`default_nettype none

module utch_front (
    input  wire                  clk,
    input  wire                  rst_n,
    input  utch_pkg::cfg_t       cfg,
    input  wire                  cmd_valid,
    output logic                 cmd_stall,
    input  utch_pkg::cmd_item_t  cmd_item,
    input  wire                  q_full,
    output utch_pkg::reply_push_t push
);

    import utch_pkg::*;

    logic       accept;
    logic       receiving_reg, receiving_next;
    logic       pending_reg, pending_next;
    logic [1:0] frame_count_reg, frame_count_next;
    logic       boost_reg, boost_next;
    logic [7:0] frame_bytes_reg [3];
    logic       fb_we;
    logic [1:0] fb_idx;
    logic [7:0] frame_sum;

    // Items are held off only while the reply queue has no room.
    assign cmd_stall = q_full;
    assign accept    = cmd_valid && !q_full;

    assign frame_sum = frame_bytes_reg[0] + frame_bytes_reg[1] + frame_bytes_reg[2];

    // Classify the item and decide the state update and the reply.
    always_comb
    begin
        receiving_next   = receiving_reg;
        pending_next     = pending_reg;
        frame_count_next = frame_count_reg;
        boost_next       = boost_reg;
        fb_we            = 1'b0;
        fb_idx           = frame_count_reg;
        push             = '0;

        if (accept)
        begin
            if (!cfg.enable)
            begin
                receiving_next   = 1'b0;
                pending_next     = 1'b0;
                frame_count_next = '0;
                boost_next       = 1'b0;
            end
            else if (pending_reg)
            begin
                // Second telemetry group goes out as zeros on the next empty event.
                if (cmd_item.op == OP_TX_EMPTY)
                begin
                    push.valid       = 1'b1;
                    pending_next     = 1'b0;
                    frame_count_next = '0;
                end
            end
            else if (cmd_item.op == OP_TX_EMPTY || cmd_item.framing_error
                     || cmd_item.overrun)
            begin
                // Nothing to do for this item.
            end
            else if (!receiving_reg)
            begin
                case (cmd_item.rx_byte)
                    CH_TELEMETRY:
                    begin
                        push.valid              = 1'b1;
                        push.reply.bytes[0]     = cmd_item.output_voltage[7:0];
                        push.reply.bytes[1]     = cmd_item.output_voltage[15:8];
                        push.reply.bytes[2]     = cmd_item.input_voltage[7:0];
                        push.reply.bytes[3]     = cmd_item.input_voltage[15:8];
                        push.reply.bytes[4]     = cmd_item.phase_current_a[7:0];
                        push.reply.bytes[5]     = cmd_item.phase_current_a[15:8];
                        push.reply.bytes[6]     = cmd_item.phase_current_b[7:0];
                        push.reply.bytes[7]     = cmd_item.phase_current_b[15:8];
                        pending_next            = 1'b1;
                        frame_count_next        = 2'd1;
                    end
                    CH_VERSION:
                    begin
                        push.valid          = 1'b1;
                        push.reply.bytes[0] = CH_VER_TAG;
                        push.reply.bytes[1] = cfg.version_word[0][7:0];
                        push.reply.bytes[2] = cfg.version_word[0][15:8];
                        push.reply.bytes[3] = cfg.version_word[1][7:0];
                        push.reply.bytes[4] = cfg.version_word[1][15:8];
                        push.reply.bytes[5] = cfg.version_word[2][7:0];
                        push.reply.bytes[6] = cfg.version_word[2][15:8];
                        push.reply.bytes[7] = cfg.version_check_byte;
                    end
                    CH_BUCK, CH_BOOST:
                    begin
                        fb_we            = 1'b1;
                        fb_idx           = 2'd0;
                        receiving_next   = 1'b1;
                        frame_count_next = 2'd1;
                        boost_next       = (cmd_item.rx_byte == CH_BOOST);
                    end
                    default:
                    begin
                        // Unknown first character is ignored.
                    end
                endcase
            end
            else if (frame_count_reg != 2'd3)
            begin
                // Value bytes of the frame.
                fb_we            = 1'b1;
                frame_count_next = frame_count_reg + 2'd1;
            end
            else
            begin
                // Checksum byte closes the frame.
                receiving_next   = 1'b0;
                frame_count_next = '0;
                if (frame_sum == cmd_item.rx_byte)
                begin
                    push.valid            = 1'b1;
                    push.reply.bytes[0]   = frame_bytes_reg[0];
                    push.reply.bytes[1]   = frame_bytes_reg[1];
                    push.reply.bytes[2]   = frame_bytes_reg[2];
                    push.reply.bytes[3]   = CH_ZERO;
                    push.reply.bytes[4]   = CH_ZERO;
                    push.reply.bytes[5]   = CH_LOW_A;
                    push.reply.bytes[6]   = CH_LOW_C;
                    push.reply.bytes[7]   = CH_LOW_K;
                    push.reply.vref_write = !boost_reg;
                    push.reply.vref_value = {frame_bytes_reg[2], frame_bytes_reg[1]};
                end
            end
        end
    end

    // Control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            receiving_reg   <= 1'b0;
            pending_reg     <= 1'b0;
            frame_count_reg <= '0;
            boost_reg       <= 1'b0;
        end
        else
        begin
            receiving_reg   <= receiving_next;
            pending_reg     <= pending_next;
            frame_count_reg <= frame_count_next;
            boost_reg       <= boost_next;
        end
    end

    // Frame bytes are only read after they have been written.
    always_ff @(posedge clk)
    begin
        if (fb_we)
        begin
            frame_bytes_reg[fb_idx] <= cmd_item.rx_byte;
        end
    end

endmodule

`default_nettype wire

// ----- src/utch_queue.sv -----
// ----------------------------------------------------------------------------
// utch_queue
// Short first-in first-out queue of complete replies between the front end
// and the byte sender.
// ----------------------------------------------------------------------------
`default_nettype none

module utch_queue #(
    parameter int DEPTH = 2
) (
    input  wire                   clk,
    input  wire                   rst_n,
    input  utch_pkg::reply_push_t push,
    input  wire                   pop,
    output utch_pkg::reply_t      head,
    output logic                  empty,
    output logic                  full
);

    import utch_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

    reply_t           entry_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_push;
    logic             do_pop;

    assign empty   = (count_reg == '0);
    assign full    = (count_reg == CNT_FULL);
    assign head    = entry_reg[rd_ptr_reg];
    assign do_push = push.valid && !full;
    assign do_pop  = pop && !empty;

    // Pointer and fill count update.
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Entry storage.
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_ptr_reg] <= push.reply;
        end
    end

endmodule

`default_nettype wire

// ----- src/utch_back.sv -----
// ----------------------------------------------------------------------------
// utch_back
// Takes replies from the queue and sends them one byte per cycle, unless
// rsp_stall holds the output, through a registered output item.
// ----------------------------------------------------------------------------
`default_nettype none

module utch_back (
    input  wire                 clk,
    input  wire                 rst_n,
    input  utch_pkg::reply_t    head,
    input  wire                 q_empty,
    output logic                pop,
    output logic                rsp_valid,
    input  wire                 rsp_stall,
    output utch_pkg::rsp_item_t rsp_item
);

    import utch_pkg::*;

    reply_t                cur_reg, cur_next;
    logic [BYTE_IDX_W-1:0] cnt_reg, cnt_next;
    logic                  active_reg, active_next;
    logic                  rsp_valid_reg, rsp_valid_next;
    rsp_item_t             rsp_item_reg, rsp_item_next;
    logic                  advance;
    reply_t                src;
    logic [BYTE_IDX_W-1:0] idx;

    assign rsp_valid = rsp_valid_reg;
    assign rsp_item  = rsp_item_reg;

    // The output register moves when it is empty or being taken.
    assign advance = !rsp_valid_reg || !rsp_stall;

    // Byte sequencing: continue the current reply, or start the next one
    // straight from the queue head without a gap.
    always_comb
    begin
        cur_next       = cur_reg;
        cnt_next       = cnt_reg;
        active_next    = active_reg;
        rsp_valid_next = rsp_valid_reg;
        rsp_item_next  = rsp_item_reg;
        pop            = 1'b0;
        src            = active_reg ? cur_reg : head;
        idx            = active_reg ? cnt_reg : '0;

        if (advance)
        begin
            if (active_reg || !q_empty)
            begin
                rsp_valid_next           = 1'b1;
                rsp_item_next.tx_byte    = src.bytes[idx];
                rsp_item_next.last       = (idx == LAST_BYTE);
                rsp_item_next.vref_write = (idx == LAST_BYTE) && src.vref_write;
                rsp_item_next.vref_value = src.vref_value;
                if (active_reg)
                begin
                    cnt_next    = cnt_reg + 1'b1;
                    active_next = (cnt_reg != LAST_BYTE);
                end
                else
                begin
                    pop         = 1'b1;
                    cur_next    = head;
                    cnt_next    = BYTE_IDX_W'(1);
                    active_next = 1'b1;
                end
            end
            else
            begin
                rsp_valid_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg       <= '0;
            active_reg    <= 1'b0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            cnt_reg       <= cnt_next;
            active_reg    <= active_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        cur_reg      <= cur_next;
        rsp_item_reg <= rsp_item_next;
    end

endmodule

`default_nettype wire

// ----- src/uart_telemetry_command_handler_top.sv -----
// Serial telemetry and command handler. Each input item is one received byte
// or one transmitter-empty event; an item that calls for a reply produces
// exactly eight result items, one per cycle unless stalled, the final one
// marked by last. Items with no reply are taken every cycle; input is stalled
// only while the queue is full. A reply is built whole when its item is
// accepted and placed in a queue of QUEUE_DEPTH replies; the byte sender
// drains it at one byte per cycle unless stalled, so throughput is set by the
// single output byte lane. Configuration writes are taken at once (cfg_ready
// is always high) and must be made while the block is idle.
// ----------------------------------------------------------------------------
// uart_telemetry_command_handler_top
// Top level: configuration registers, front end, reply queue, byte sender.
// ----------------------------------------------------------------------------
`default_nettype none

module uart_telemetry_command_handler_top #(
    parameter int QUEUE_DEPTH = 2
) (
    input  wire                                 clk,
    input  wire                                 rst_n,
    input  wire                                 cmd_valid,
    output logic                                cmd_stall,
    input  utch_pkg::cmd_item_t                 cmd_item,
    output logic                                rsp_valid,
    input  wire                                 rsp_stall,
    output utch_pkg::rsp_item_t                 rsp_item,
    input  wire                                 cfg_valid,
    output logic                                cfg_ready,
    input  wire [utch_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  wire [utch_pkg::CFG_DATA_W-1:0]      cfg_data
);

    import utch_pkg::*;

    cfg_t        cfg_reg, cfg_next;
    reply_push_t push;
    reply_t      head;
    logic        q_empty;
    logic        q_full;
    logic        pop;

    assign cfg_ready = 1'b1;

    // Configuration register writes; indexes past the list are ignored.
    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                REG_ENABLE:      cfg_next.enable             = cfg_data[0];
                REG_VERSION_0:   cfg_next.version_word[0]    = cfg_data;
                REG_VERSION_1:   cfg_next.version_word[1]    = cfg_data;
                REG_VERSION_2:   cfg_next.version_word[2]    = cfg_data;
                REG_VERSION_CHK: cfg_next.version_check_byte = cfg_data[7:0];
                default:         cfg_next                    = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= '{enable: 1'b1, version_word: '0, version_check_byte: 8'h00};
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    utch_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .cmd_valid (cmd_valid),
        .cmd_stall (cmd_stall),
        .cmd_item  (cmd_item),
        .q_full    (q_full),
        .push      (push)
    );

    utch_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (push),
        .pop   (pop),
        .head  (head),
        .empty (q_empty),
        .full  (q_full)
    );

    utch_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .head      (head),
        .q_empty   (q_empty),
        .pop       (pop),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp_item  (rsp_item)
    );

    // Checks.
`include "uart_telemetry_command_handler_top_assert.svh"

    `UTCH_ASSERT_IMP(a_no_push_when_full, push.valid, !q_full,
                     "reply pushed into a full queue")
    `UTCH_ASSERT_IMP(a_disabled_silent, cmd_valid && !cmd_stall && !cfg_reg.enable,
                     !push.valid, "reply built while disabled")
    `UTCH_ASSERT_IMP(a_vref_on_last, rsp_valid && rsp_item.vref_write, rsp_item.last,
                     "reference write not on final byte")
    `UTCH_ASSERT_NXT(a_pop_starts_reply, pop, rsp_valid && !rsp_item.last,
                     "reply start did not reach the output")

endmodule

`default_nettype wire
